// ----- hw/rtl/fkm_pkg.sv -----
// Shared types, constants and the key hash of the feature key id mapper.
package fkm_pkg;

  localparam int ENTRIES = 1024;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = IDX_W + 1;
  localparam int CMD_W   = 2;
  localparam int GRP_W   = 16;
  localparam int FEAT_W  = 64;
  localparam int ID_W    = 64;
  localparam int STAT_W  = 2;
  localparam int KEY_W   = GRP_W + FEAT_W;

  localparam logic [CMD_W-1:0] CMD_FIT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_XFORM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd2;

  localparam logic [STAT_W-1:0] ST_FOUND  = 2'd0;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  localparam logic [ID_W-1:0] ID_MAX = '1;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [GRP_W-1:0]  group_number;
    logic [FEAT_W-1:0] feature_key;
    logic [ID_W-1:0]   given_id;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   mapped_id;
  } rsp_t;

  typedef struct packed {
    logic              valid;
    logic [GRP_W-1:0]  group_number;
    logic [FEAT_W-1:0] feature_key;
    logic [ID_W-1:0]   value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Fold the key down to a table index by XOR of its slices.
  function automatic logic [IDX_W-1:0] key_hash(input logic [GRP_W-1:0] grp,
                                                input logic [FEAT_W-1:0] feat);
    logic [KEY_W-1:0] k;
    logic [IDX_W-1:0] h;
    k = {grp, feat};
    h = '0;
    for (int i = 0; i < KEY_W; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ k[i];
    end
    return h;
  endfunction

  function automatic logic [ID_W-1:0] sat_inc(input logic [ID_W-1:0] v);
    return (v == ID_MAX) ? ID_MAX : v + ID_W'(1);
  endfunction

endpackage

// ----- hw/rtl/fkm_ram.sv -----
// Simple dual-port RAM with registered read data.
module fkm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/feature_key_id_mapper_core.sv -----
// Top level of the feature key id mapper: hashed key table and id allocation.
//
//  channel | signals                      | direction | carries
//  --------+------------------------------+-----------+------------------------------
//  in      | in_valid in_ready in_req     | input     | command, group, key, given id
//  out     | out_valid out_ready out_rsp  | output    | status, mapped id
//  cfg     | cfg_we cfg_wdata             | input     | base id, no read-back
//
// A request passes the read and check states once per probe of the linear search
// in the single table RAM, then the done state; one request is handled at a time.
// After reset a clearing pass wipes the valid bits of the RAM;
// no request is taken meanwhile, configuration writes are.
// A finished response waits in the output register; the next request is
// taken while it waits, and the one after stalls until it is taken.
module feature_key_id_mapper_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  fkm_pkg::req_t              in_req,
  output logic                       out_valid,
  input  logic                       out_ready,
  output fkm_pkg::rsp_t              out_rsp,
  input  logic                       cfg_we,
  input  logic [fkm_pkg::ID_W-1:0]   cfg_wdata
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                          state;
  fkm_pkg::req_t                   req;
  fkm_pkg::rsp_t                   res;
  logic [fkm_pkg::IDX_W-1:0]       probe;
  logic [fkm_pkg::IDX_W-1:0]       probes;
  logic [fkm_pkg::IDX_W-1:0]       clr_addr;
  logic [fkm_pkg::CNT_W-1:0]       count;
  logic [fkm_pkg::ID_W-1:0]        nfid;
  logic [fkm_pkg::ID_W-1:0]        nfid_next;

  // Table RAM hookup.
  logic                            ram_we;
  logic [fkm_pkg::IDX_W-1:0]       ram_waddr;
  fkm_pkg::entry_t                 ram_wdata;
  fkm_pkg::entry_t                 rd;
  fkm_pkg::entry_t                 wr_entry;

  logic hit, empty, last_probe, probe_end, full, is_fit, is_load;
  logic do_write, new_entry, out_load;
  fkm_pkg::rsp_t res_next;

  fkm_ram #(.DEPTH(fkm_pkg::ENTRIES), .WIDTH(fkm_pkg::ENTRY_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (state == S_READ),
    .raddr (probe),
    .rdata (rd)
  );

  assign in_ready = (state == S_IDLE);

  // Load the output register once the previous response has gone or is going.
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // Decide on the slot just read: match, free slot, or keep probing.
  always_comb begin
    is_fit     = (req.command == fkm_pkg::CMD_FIT);
    is_load    = (req.command == fkm_pkg::CMD_LOAD);
    hit        = rd.valid && (rd.group_number == req.group_number)
                 && (rd.feature_key == req.feature_key);
    empty      = !rd.valid;
    last_probe = (probes == fkm_pkg::IDX_W'(fkm_pkg::ENTRIES - 1));
    probe_end  = hit || empty || last_probe;
    full       = (count == fkm_pkg::CNT_W'(fkm_pkg::ENTRIES));
    do_write   = probe_end && ((is_load && (hit || !full)) || (is_fit && !hit && !full));
    new_entry  = do_write && !hit;

    wr_entry.valid        = 1'b1;
    wr_entry.group_number = req.group_number;
    wr_entry.feature_key  = req.feature_key;
    wr_entry.value        = is_load ? req.given_id : nfid;

    res_next.status    = fkm_pkg::ST_FOUND;
    res_next.mapped_id = '0;
    if (hit) begin
      res_next.mapped_id = is_load ? req.given_id : rd.value;
    end else if ((is_fit || is_load) && full) begin
      res_next.status = fkm_pkg::ST_FULL;
    end else begin
      res_next.status = fkm_pkg::ST_ABSENT;
      if (is_load) begin
        res_next.mapped_id = req.given_id;
      end else if (is_fit) begin
        res_next.mapped_id = nfid;
      end
    end

    nfid_next = nfid;
    if (do_write && is_load) begin
      if (req.given_id >= nfid) begin
        nfid_next = fkm_pkg::sat_inc(req.given_id);
      end
    end else if (do_write && is_fit) begin
      nfid_next = fkm_pkg::sat_inc(nfid);
    end
  end

  always_comb begin
    ram_we    = (state == S_CLEAR) || ((state == S_CHECK) && do_write);
    ram_waddr = (state == S_CLEAR) ? clr_addr : probe;
    ram_wdata = (state == S_CLEAR) ? '0 : wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      count     <= '0;
      nfid      <= '0;
      out_valid <= 1'b0;
    end else begin
      // The user must write configuration only while idle, not enforced here; reload
      // the next id on an empty table, otherwise the written base id has no effect.
      if (cfg_we) begin
        if (count == '0) begin
          nfid <= cfg_wdata;
        end
      end else if (state == S_CHECK) begin
        nfid <= nfid_next;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + fkm_pkg::IDX_W'(1);
          if (clr_addr == fkm_pkg::IDX_W'(fkm_pkg::ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req    <= in_req;
            probe  <= fkm_pkg::key_hash(in_req.group_number, in_req.feature_key);
            probes <= '0;
            state  <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (probe_end) begin
            res   <= res_next;
            state <= S_DONE;
            if (new_entry) begin
              count <= count + fkm_pkg::CNT_W'(1);
            end
          end else begin
            // Advance to the neighbouring slot.
            probe  <= probe + fkm_pkg::IDX_W'(1);
            probes <= probes + fkm_pkg::IDX_W'(1);
            state  <= S_READ;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_rsp <= res;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= fkm_pkg::CNT_W'(fkm_pkg::ENTRIES))
    else $error("entry count beyond table size");

  a_nfid_mono: assert property (@(posedge clk) disable iff (rst)
    !cfg_we |=> nfid >= $past(nfid))
    else $error("next free id went backwards");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready)
    else $error("request taken during clearing pass");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && ($past(state) != S_CHECK) |-> $stable(count))
    else $error("entry count changed outside check");

endmodule
